// ----- rtl/sui_pkg.sv -----
// ----------------------------------------------------------------------------
// sui_pkg
// Shared types, sizes and codes for the set union / intersection block.
// ----------------------------------------------------------------------------
package sui_pkg;

  localparam int DEPTH = 16;
  localparam int DW    = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  typedef logic [CW-1:0] count_t;
  typedef logic [AW-1:0] addr_t;
  typedef logic [DW-1:0] word_t;

  typedef enum logic [1:0] {
    MODE_FIRST  = 2'd0,
    MODE_SECOND = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_UNION = 2'd0,
    KIND_INTER = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UF,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_IN,
    ST_END
  } state_t;

  // US: second-list elements checked against the first list
  // IS: first-list elements checked against the second list
  typedef enum logic {
    PH_US,
    PH_IS
  } phase_t;

endpackage

// ----- rtl/set_union_intersection.sv -----
// ----------------------------------------------------------------------------
// set_union_intersection
// Loads two lists into RAMs, then streams their union and intersection.
// ----------------------------------------------------------------------------
// Append words (mode first/second) leave busy low. A finish word raises busy
// until the end marker has been issued. The first list streams out at one
// word per cycle, through the RAM read register and the result register.
// Each membership test then reads the other RAM one entry per cycle and stops
// on the first match. Results come out on the strobe and cannot be held off;
// the end marker shows while busy has already dropped.
// ----------------------------------------------------------------------------
module set_union_intersection (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode,
  input  logic signed [31:0]  value,
  output logic                strobe,
  output logic [1:0]          list_kind,
  output logic signed [31:0]  value_res,
  output logic                overflow,
  output logic                last
);
  import sui_pkg::*;

  state_t state, state_next;
  phase_t phase, phase_next;
  count_t first_count, second_count;
  count_t oi, oi_next, ii, ii_next;
  word_t  x, x_next;
  logic   pend, pend_next;
  logic   overflow_seen;

  addr_t  first_raddr, second_raddr;
  word_t  first_rdata, second_rdata;
  logic   first_we, second_we;
  logic   accept;

  logic   emit;
  kind_t  emit_kind;
  word_t  emit_val;
  logic   emit_last;

  count_t ocnt, icnt;
  word_t  inner_rdata;
  logic   match_now;

  sui_ram #(.DW(DW), .AW(AW)) u_first (
    .clk   (clk),
    .we    (first_we),
    .waddr (first_count[AW-1:0]),
    .wdata (value),
    .raddr (first_raddr),
    .rdata (first_rdata)
  );

  sui_ram #(.DW(DW), .AW(AW)) u_second (
    .clk   (clk),
    .we    (second_we),
    .waddr (second_count[AW-1:0]),
    .wdata (value),
    .raddr (second_raddr),
    .rdata (second_rdata)
  );

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign first_we  = accept && (mode == MODE_FIRST) && (first_count < count_t'(DEPTH));
  assign second_we = accept && (mode == MODE_SECOND) && (second_count < count_t'(DEPTH));

  // outer / inner list roles per phase
  assign ocnt        = (phase == PH_US) ? second_count : first_count;
  assign icnt        = (phase == PH_US) ? first_count : second_count;
  assign inner_rdata = (phase == PH_US) ? first_rdata : second_rdata;
  // a read is in flight once ii has moved past zero
  assign match_now   = (ii != '0) && (inner_rdata == x);

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    oi_next      = oi;
    ii_next      = ii;
    x_next       = x;
    pend_next    = 1'b0;
    first_raddr  = oi[AW-1:0];
    second_raddr = oi[AW-1:0];
    emit         = 1'b0;
    emit_kind    = KIND_UNION;
    emit_val     = '0;
    emit_last    = 1'b0;

    // first list streams through the read pipeline
    if (pend) begin
      emit     = 1'b1;
      emit_val = first_rdata;
    end

    unique case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_FINISH) begin
          state_next = ST_UF;
          oi_next    = '0;
        end
      end
      ST_UF: begin
        if (oi < first_count) begin
          first_raddr = oi[AW-1:0];
          oi_next     = oi + count_t'(1);
          pend_next   = 1'b1;
        end else begin
          oi_next    = '0;
          phase_next = PH_US;
          state_next = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        if (oi < ocnt) begin
          state_next = ST_OUT_LD;
        end else if (phase == PH_US) begin
          phase_next = PH_IS;
          oi_next    = '0;
        end else begin
          state_next = ST_END;
        end
      end
      ST_OUT_LD: begin
        x_next     = (phase == PH_US) ? second_rdata : first_rdata;
        ii_next    = '0;
        state_next = ST_IN;
      end
      ST_IN: begin
        if (match_now || ii == icnt) begin
          emit       = (phase == PH_US) ? !match_now : match_now;
          emit_kind  = (phase == PH_US) ? KIND_UNION : KIND_INTER;
          emit_val   = x;
          oi_next    = oi + count_t'(1);
          state_next = ST_OUT_RD;
        end else begin
          if (phase == PH_US) begin
            first_raddr = ii[AW-1:0];
          end else begin
            second_raddr = ii[AW-1:0];
          end
          ii_next = ii + count_t'(1);
        end
      end
      ST_END: begin
        emit       = 1'b1;
        emit_kind  = KIND_END;
        emit_last  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    phase <= phase_next;
    oi    <= oi_next;
    ii    <= ii_next;
    x     <= x_next;
  end

  // list counts and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
    end else if (state == ST_END) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (first_we) begin
        first_count <= first_count + count_t'(1);
      end
      if (second_we) begin
        second_count <= second_count + count_t'(1);
      end
      if (accept && ((mode == MODE_FIRST && !first_we) ||
                     (mode == MODE_SECOND && !second_we))) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    list_kind <= emit_kind;
    value_res <= emit_val;
    overflow  <= overflow_seen;
    last      <= emit_last;
  end

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("end marker shown while still busy");

  a_body_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("list word shown outside a finish");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode == MODE_FINISH |=> busy)
    else $error("finish word did not start the scan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    first_count <= count_t'(DEPTH) && second_count <= count_t'(DEPTH))
    else $error("list count beyond depth");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> value_res == '0 && list_kind == KIND_END)
    else $error("end marker carries a value");

endmodule

// ----- rtl/sui_ram.sv -----
// ----------------------------------------------------------------------------
// sui_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sui_ram #(
  parameter int DW = 32,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
